### hdl/cipher_key_square_builder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key square builder
// Shared helpers for the port checker; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CIPHER_KEY_SQUARE_BUILDER_ASSERT_SVH
`define CIPHER_KEY_SQUARE_BUILDER_ASSERT_SVH

// General property, ignored while reset is held.
`define CKSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must hold on every result transfer offered.
`define CKSB_ASSERT_OUT(lbl, cond, msg) \
    `CKSB_ASSERT(lbl, o_out_valid |-> (cond), msg)

`endif

### hdl/cksb_pkg.sv
// ----------------------------------------------------------------------------
// cksb_pkg
// Types, codes and helpers shared by the key square builder modules.
// ----------------------------------------------------------------------------
package cksb_pkg;

    localparam int MAX_CELLS_DEF   = 256;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int DIM_W    = 5;   // width/height register
    localparam int COORD_W  = 4;   // row/column field
    localparam int POS_W    = 8;   // packed {row, col}
    localparam int SYM_W    = 8;   // symbol port
    localparam int FILLED_W = 9;   // filled port and capacity
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd5;
    localparam logic [DIM_W-1:0] DIM_MIN   = 5'd1;
    localparam logic [DIM_W-1:0] DIM_MAX   = 5'd16;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_DUPLICATE   = 3'd1,
        STATUS_OVERFLOW    = 3'd2,
        STATUS_NOT_PRESENT = 3'd3,
        STATUS_CELL_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic rd;       // read the stores
        logic commit;   // update state, load result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // result register can take a new result
    } t_sts;

    // zero acts as one, anything above sixteen as sixteen
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/cksb_ctrl.sv
// ----------------------------------------------------------------------------
// cksb_ctrl
// Sequencer: accept, read the stores, then commit once the result slot is free.
// ----------------------------------------------------------------------------
module cksb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cksb_pkg::t_sts  i_sts,
    output cksb_pkg::t_cmd  o_cmd
);

    cksb_pkg::t_state r_state;
    cksb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cksb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            cksb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = cksb_pkg::S_READ;
                end
            end
            cksb_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = cksb_pkg::S_EXEC;
            end
            cksb_pkg::S_EXEC: begin
                // hold here while the previous result is still unclaimed
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = cksb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cksb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hdl/cksb_dpath.sv
// ----------------------------------------------------------------------------
// cksb_dpath
// Seen bits, position and cell stores, fill counters and result register.
// ----------------------------------------------------------------------------
module cksb_dpath #(
    parameter int MAX_CELLS   = cksb_pkg::MAX_CELLS_DEF,
    parameter int SYMBOL_BITS = cksb_pkg::SYMBOL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cksb_pkg::t_cmd                    i_cmd,
    output cksb_pkg::t_sts                    o_sts,
    // item fields
    input  logic [1:0]                        i_action,
    input  logic [cksb_pkg::SYM_W-1:0]        i_symbol,
    input  logic [cksb_pkg::COORD_W-1:0]      i_col_in,
    input  logic [cksb_pkg::COORD_W-1:0]      i_row_in,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [cksb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cksb_pkg::DIM_W-1:0]        i_cfg_data,
    // result
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cksb_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_found,
    output logic [cksb_pkg::COORD_W-1:0]      o_row_out,
    output logic [cksb_pkg::COORD_W-1:0]      o_col_out,
    output logic [cksb_pkg::SYM_W-1:0]        o_symbol_out,
    output logic [cksb_pkg::FILLED_W-1:0]     o_filled,
    output logic                              o_complete
);

    localparam int SYM_COUNT = 2 ** SYMBOL_BITS;
    localparam int CA_W      = $clog2(MAX_CELLS);
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int DW        = cksb_pkg::DIM_W;
    localparam int CW        = cksb_pkg::COORD_W;
    localparam int FW        = cksb_pkg::FILLED_W;
    localparam logic [FW-1:0] MAX_CELLS_F = FW'(MAX_CELLS);

    // configuration
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;

    // captured item
    cksb_pkg::t_action         r_action;
    logic [SYMBOL_BITS-1:0]    r_sym;
    logic [CW-1:0]             r_col;
    logic [CW-1:0]             r_row;

    // table state
    logic [SYM_COUNT-1:0]      r_seen;
    logic [SYM_COUNT-1:0]      n_seen;
    logic [CW-1:0]             r_next_col;
    logic [CW-1:0]             n_next_col;
    logic [DW-1:0]             r_next_row;
    logic [DW-1:0]             n_next_row;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          n_fill;

    logic [cksb_pkg::POS_W-1:0] r_pos_mem [SYM_COUNT];
    logic [SYMBOL_BITS-1:0]     r_cell_mem [MAX_CELLS];
    logic [cksb_pkg::POS_W-1:0] r_pos_rd;
    logic [SYMBOL_BITS-1:0]     r_cell_rd;

    // result register
    logic                      r_out_valid;
    logic                      n_out_valid;
    cksb_pkg::t_status         r_status;
    cksb_pkg::t_status         n_status;
    logic                      r_found;
    logic                      n_found;
    logic [CW-1:0]             r_row_out;
    logic [CW-1:0]             n_row_out;
    logic [CW-1:0]             r_col_out;
    logic [CW-1:0]             n_col_out;
    logic [SYMBOL_BITS-1:0]    r_sym_out;
    logic [SYMBOL_BITS-1:0]    n_sym_out;
    logic [CNT_W-1:0]          r_filled;
    logic                      r_complete;

    logic [DW-1:0]             dim_w;
    logic [DW-1:0]             dim_h;
    logic [FW-1:0]             cap_raw;
    logic [FW-1:0]             cap;
    logic [FW-1:0]             rd_idx;
    logic [DW-1:0]             col_inc;
    logic                      pos_we;
    logic                      cell_we;

    assign dim_w   = cksb_pkg::clamp_dim(r_width);
    assign dim_h   = cksb_pkg::clamp_dim(r_height);
    assign cap_raw = FW'(dim_w) * FW'(dim_h);
    assign cap     = (cap_raw < MAX_CELLS_F) ? cap_raw : MAX_CELLS_F;
    assign rd_idx  = FW'(r_col) + FW'(r_row) * FW'(dim_w);
    assign col_inc = DW'(r_next_col) + DW'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cksb_pkg::DIM_RESET;
            r_height <= cksb_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (cksb_pkg::t_cfg_reg'(i_cfg_index))
                cksb_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                cksb_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= cksb_pkg::t_action'(i_action);
            r_sym    <= i_symbol[SYMBOL_BITS-1:0];
            r_col    <= i_col_in;
            r_row    <= i_row_in;
        end
    end

    // stores: registered reads in the read step, writes on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_pos_rd  <= r_pos_mem[r_sym];
            r_cell_rd <= r_cell_mem[rd_idx[CA_W-1:0]];
        end
        if (i_cmd.commit && pos_we) begin
            r_pos_mem[r_sym] <= {r_next_row[CW-1:0], r_next_col};
        end
        if (i_cmd.commit && cell_we) begin
            r_cell_mem[r_fill[CA_W-1:0]] <= r_sym;
        end
    end

    // item evaluation
    always_comb begin
        n_status   = cksb_pkg::STATUS_OK;
        n_found    = 1'b0;
        n_row_out  = '0;
        n_col_out  = '0;
        n_sym_out  = '0;
        n_seen     = r_seen;
        n_next_col = r_next_col;
        n_next_row = r_next_row;
        n_fill     = r_fill;
        pos_we     = 1'b0;
        cell_we    = 1'b0;
        case (r_action)
            cksb_pkg::ACT_CLEAR: begin
                n_seen     = '0;
                n_next_col = '0;
                n_next_row = '0;
                n_fill     = '0;
            end
            cksb_pkg::ACT_INSERT: begin
                if (r_seen[r_sym]) begin
                    n_status  = cksb_pkg::STATUS_DUPLICATE;
                    n_found   = 1'b1;
                    n_row_out = r_pos_rd[2*CW-1:CW];
                    n_col_out = r_pos_rd[CW-1:0];
                end else if (FW'(r_fill) >= cap || r_next_row >= dim_h) begin
                    n_status = cksb_pkg::STATUS_OVERFLOW;
                end else begin
                    n_found       = 1'b1;
                    n_row_out     = r_next_row[CW-1:0];
                    n_col_out     = r_next_col;
                    n_seen[r_sym] = 1'b1;
                    pos_we        = 1'b1;
                    cell_we       = 1'b1;
                    n_fill        = r_fill + CNT_W'(1);
                    // raster order, column wraps at the current width
                    if (col_inc >= dim_w) begin
                        n_next_col = '0;
                        n_next_row = r_next_row + DW'(1);
                    end else begin
                        n_next_col = col_inc[CW-1:0];
                    end
                end
            end
            cksb_pkg::ACT_LOOKUP: begin
                if (r_seen[r_sym]) begin
                    n_found   = 1'b1;
                    n_row_out = r_pos_rd[2*CW-1:CW];
                    n_col_out = r_pos_rd[CW-1:0];
                end else begin
                    n_status = cksb_pkg::STATUS_NOT_PRESENT;
                end
            end
            cksb_pkg::ACT_READ: begin
                if (DW'(r_col) >= dim_w || DW'(r_row) >= dim_h || rd_idx >= FW'(r_fill)) begin
                    n_status = cksb_pkg::STATUS_CELL_EMPTY;
                end else begin
                    n_sym_out = r_cell_rd;
                end
            end
            default: ;
        endcase
    end

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_next_col <= '0;
            r_next_row <= '0;
            r_fill     <= '0;
        end else if (i_cmd.commit) begin
            r_seen     <= n_seen;
            r_next_col <= n_next_col;
            r_next_row <= n_next_row;
            r_fill     <= n_fill;
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_found    <= n_found;
            r_row_out  <= n_row_out;
            r_col_out  <= n_col_out;
            r_sym_out  <= n_sym_out;
            r_filled   <= n_fill;
            r_complete <= (FW'(n_fill) == cap);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_row_out    = r_row_out;
    assign o_col_out    = r_col_out;
    assign o_symbol_out = cksb_pkg::SYM_W'(r_sym_out);
    assign o_filled     = FW'(r_filled);
    assign o_complete   = r_complete;

endmodule

### hdl/cipher_key_square_builder.sv
// ----------------------------------------------------------------------------
// cipher_key_square_builder
// Key square builder for a Playfair-style cipher: insert, lookup, read, clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Item channel (i_in_valid/o_in_ready): action, symbol, col_in, row_in.
//    Stream key symbols then alphabet symbols as inserts; each new symbol
//    takes the next raster cell, duplicates are reported and dropped.
//  - Result channel (o_out_valid/i_out_ready): one result per item with
//    status, found, row/col, symbol at the read cell, filled and complete.
//  - Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets
//    the square width, index 1 the height. Write only while idle.
//  - After the item transfer the position and cell memories are read into
//    registers, then the item is evaluated into the result register. A new
//    item is taken only after the previous one has been committed.
//  - A stalled receiver holds the result register; the next item is still
//    taken and read, then waits in evaluation until the slot frees up.
//  - Reset: width and height return to 5, the square is empty (seen bits
//    cleared by reset), no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module cipher_key_square_builder #(
    parameter int MAX_CELLS   = cksb_pkg::MAX_CELLS_DEF,
    parameter int SYMBOL_BITS = cksb_pkg::SYMBOL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [cksb_pkg::SYM_W-1:0]        i_symbol,
    input  logic [cksb_pkg::COORD_W-1:0]      i_col_in,
    input  logic [cksb_pkg::COORD_W-1:0]      i_row_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cksb_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_found,
    output logic [cksb_pkg::COORD_W-1:0]      o_row_out,
    output logic [cksb_pkg::COORD_W-1:0]      o_col_out,
    output logic [cksb_pkg::SYM_W-1:0]        o_symbol_out,
    output logic [cksb_pkg::FILLED_W-1:0]     o_filled,
    output logic                              o_complete,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cksb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cksb_pkg::DIM_W-1:0]        i_cfg_data
);

    cksb_pkg::t_cmd cmd;
    cksb_pkg::t_sts sts;

    // register writes are captured directly, never back-pressured
    assign o_cfg_ready = 1'b1;

    cksb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cksb_dpath #(
        .MAX_CELLS   (MAX_CELLS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_action),
        .i_symbol     (i_symbol),
        .i_col_in     (i_col_in),
        .i_row_in     (i_row_in),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found      (o_found),
        .o_row_out    (o_row_out),
        .o_col_out    (o_col_out),
        .o_symbol_out (o_symbol_out),
        .o_filled     (o_filled),
        .o_complete   (o_complete)
    );

endmodule

### hdl/cksb_checker.sv
// ----------------------------------------------------------------------------
// cksb_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "cipher_key_square_builder_assert.svh"

module cksb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [cksb_pkg::STATUS_W-1:0]     o_status,
    input logic                              o_found,
    input logic [cksb_pkg::COORD_W-1:0]      o_row_out,
    input logic [cksb_pkg::COORD_W-1:0]      o_col_out,
    input logic [cksb_pkg::FILLED_W-1:0]     o_filled,
    input logic                              o_complete
);

    // stalled result stays offered with the same status
    `CKSB_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status), "result dropped or changed while stalled")

    // a full square is never empty
    `CKSB_ASSERT_OUT(a_complete_nonempty, !o_complete || o_filled != '0, "complete with no cells filled")

    // refused or missing symbols carry no position
    `CKSB_ASSERT_OUT(a_miss_no_pos, !(o_status == cksb_pkg::STATUS_NOT_PRESENT || o_status == cksb_pkg::STATUS_OVERFLOW) || (!o_found && o_row_out == '0 && o_col_out == '0), "miss reports a position")

    // a duplicate always points at its existing cell
    `CKSB_ASSERT_OUT(a_dup_found, o_status != cksb_pkg::STATUS_DUPLICATE || o_found, "duplicate without found")

endmodule

bind cipher_key_square_builder cksb_checker u_cksb_checker (.*);
